@@ rtl/core/cst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Shared codes and defaults for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int NUM_SEMS_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 16;

    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_DESTROY = 3'd1;
    localparam logic [2:0] OP_POST    = 3'd2;
    localparam logic [2:0] OP_WAIT    = 3'd3;
    localparam logic [2:0] OP_CHECK   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage
`default_nettype wire

@@ rtl/core/counting_semaphore_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit
// Table of counting semaphores with a FIFO of waiting pids per entry.
// ----------------------------------------------------------------------------
// Usage: drive opcode, sem_id, init_value and caller_pid and raise start
// while busy is low; the request word is taken at that edge. The block then
// reads the entry's control word (count, queue head, queue fill) from one
// RAM, decides, and writes it back. A post walks the waiter RAM one slot
// at a time (address state, registered read) until a live pid turns up or
// the queue empties. The result word appears with done high for exactly
// one cycle; the receiver cannot stall it, so it is never held.
// Path: most requests pass the read, exec and done states; a post that
// pops queued pids adds an address and a read state per popped pid; bad
// ids and bad opcodes go from idle straight to done.
// busy stays high from accept through done and drops in the idle state,
// so a new request is taken only after the last one is through; the rate
// is set by the control-word read-modify-write plus the waiter walk.
// Reset clears the valid bits (flip-flops) and the sequencer; RAM contents
// are left as they are, since init writes an entry before it is read.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit #(
    parameter int NUM_SEMS    = cst_pkg::NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = cst_pkg::PID_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [15:0] sem_id,
    input  wire logic [31:0] init_value,
    input  wire logic [15:0] caller_pid,
    output logic             done,
    output logic [1:0]       status,
    output logic             blocked,
    output logic             wake_valid,
    output logic [15:0]      wake_pid
);

    localparam int IDW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = 32 + QW + FW;
    localparam int WD  = NUM_SEMS * QUEUE_DEPTH;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int PW  = (PID_BITS < 16) ? PID_BITS : 16;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_PADDR = 6'b001000,
        S_PREAD = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg;
    logic [IDW-1:0]     id_reg;
    logic [31:0]        ival_reg;
    logic [PW-1:0]      pid_reg;
    logic [31:0]        cnt_reg;
    logic [QW-1:0]      head_reg;
    logic [FW-1:0]      fill_reg;
    logic [NUM_SEMS-1:0] valid_reg;
    logic [1:0]         status_reg;
    logic               blocked_reg, wake_valid_reg;
    logic [PW-1:0]      wake_pid_reg;

    logic               ctl_we;
    logic [CW-1:0]      ctl_wdata, ctl_rdata;
    logic               wt_we;
    logic [WAW-1:0]     wt_addr;
    logic [PID_BITS-1:0] wt_wdata, wt_rdata;
    logic               id_ok, op_ok;
    logic [31:0]        cnt_rd;
    logic [QW-1:0]      head_rd;
    logic [FW-1:0]      fill_rd;
    logic [31:0]        cnt_inc;
    logic [QW-1:0]      tail;
    logic [QW-1:0]      head_inc;

    assign id_ok = (sem_id < 16'(NUM_SEMS));
    assign op_ok = (opcode <= cst_pkg::OP_CHECK);

    assign cnt_rd  = ctl_rdata[CW-1 -: 32];
    assign head_rd = ctl_rdata[FW +: QW];
    assign fill_rd = ctl_rdata[FW-1:0];
    assign cnt_inc = cnt_rd + 32'd1;

    // Wrap the circular index without a divider.
    always_comb
    begin
        logic [QW:0] s;
        s = (QW+1)'(head_rd) + (QW+1)'(fill_rd);
        if (s >= (QW+1)'(QUEUE_DEPTH))
        begin
            s = s - (QW+1)'(QUEUE_DEPTH);
        end
        tail = s[QW-1:0];
        if ({1'b0, head_reg} == (QW+1)'(QUEUE_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + QW'(1);
        end
    end

    cst_ram #(.WIDTH(CW), .DEPTH(NUM_SEMS)) u_ctl_ram (
        .clk   (clk),
        .we    (ctl_we),
        .addr  (id_reg),
        .wdata (ctl_wdata),
        .rdata (ctl_rdata)
    );

    cst_ram #(.WIDTH(PID_BITS), .DEPTH(WD)) u_wait_ram (
        .clk   (clk),
        .we    (wt_we),
        .addr  (wt_addr),
        .wdata (wt_wdata),
        .rdata (wt_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        ctl_we     = 1'b0;
        ctl_wdata  = {cnt_reg, head_reg, fill_reg};
        wt_we      = 1'b0;
        wt_addr    = WAW'(id_reg * QUEUE_DEPTH + head_reg);
        wt_wdata   = PID_BITS'(pid_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (id_ok && op_ok) ? S_READ : S_DONE;
                end
            end
            S_READ: state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    cst_pkg::OP_INIT:
                    begin
                        if (!valid_reg[id_reg])
                        begin
                            ctl_we    = 1'b1;
                            ctl_wdata = {ival_reg, QW'(0), FW'(0)};
                        end
                    end
                    cst_pkg::OP_POST:
                    begin
                        if (valid_reg[id_reg])
                        begin
                            ctl_we    = 1'b1;
                            ctl_wdata = {cnt_inc, head_rd, fill_rd};
                            if (cnt_inc != 32'd0 && fill_rd != '0)
                            begin
                                ctl_we     = 1'b0;
                                state_next = S_PADDR;
                            end
                        end
                    end
                    cst_pkg::OP_WAIT:
                    begin
                        if (valid_reg[id_reg])
                        begin
                            if (cnt_rd != 32'd0)
                            begin
                                ctl_we    = 1'b1;
                                ctl_wdata = {cnt_rd - 32'd1, head_rd, fill_rd};
                            end
                            else if (fill_rd < FW'(QUEUE_DEPTH))
                            begin
                                ctl_we    = 1'b1;
                                ctl_wdata = {cnt_rd, head_rd, fill_rd + FW'(1)};
                                wt_we     = 1'b1;
                                wt_addr   = WAW'(id_reg * QUEUE_DEPTH + tail);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_PADDR: state_next = S_PREAD;
            S_PREAD:
            begin
                // Pop one waiter; stop on a live pid or an empty queue.
                if (wt_rdata != '0 || fill_reg == FW'(1))
                begin
                    ctl_we     = 1'b1;
                    ctl_wdata  = {cnt_reg, head_inc, fill_reg - FW'(1)};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PADDR;
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                if (op_reg == cst_pkg::OP_INIT)
                begin
                    valid_reg[id_reg] <= 1'b1;
                end
                else if (op_reg == cst_pkg::OP_DESTROY)
                begin
                    valid_reg[id_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg         <= opcode;
                id_reg         <= IDW'(sem_id);
                ival_reg       <= init_value;
                pid_reg        <= PW'(caller_pid);
                status_reg     <= cst_pkg::ST_BAD;
                blocked_reg    <= 1'b0;
                wake_valid_reg <= 1'b0;
                wake_pid_reg   <= '0;
            end
            S_EXEC:
            begin
                cnt_reg  <= cnt_inc;
                head_reg <= head_rd;
                fill_reg <= fill_rd;
                status_reg <= cst_pkg::ST_OK;
                if (op_reg == cst_pkg::OP_INIT)
                begin
                    if (valid_reg[id_reg])
                    begin
                        status_reg <= cst_pkg::ST_BAD;
                    end
                end
                else if (!valid_reg[id_reg])
                begin
                    status_reg <= cst_pkg::ST_BAD;
                end
                else if (op_reg == cst_pkg::OP_POST && cnt_inc == 32'd0)
                begin
                    status_reg <= cst_pkg::ST_OVERFLOW;
                end
                else if (op_reg == cst_pkg::OP_WAIT && cnt_rd == 32'd0)
                begin
                    if (fill_rd < FW'(QUEUE_DEPTH))
                    begin
                        blocked_reg <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= cst_pkg::ST_FULL;
                    end
                end
            end
            S_PREAD:
            begin
                head_reg <= head_inc;
                fill_reg <= fill_reg - FW'(1);
                if (wt_rdata != '0)
                begin
                    wake_valid_reg <= 1'b1;
                    wake_pid_reg   <= PW'(wt_rdata);
                end
            end
            default: ;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign status     = status_reg;
    assign blocked    = blocked_reg;
    assign wake_valid = wake_valid_reg;
    assign wake_pid   = 16'(wake_pid_reg);

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_block_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && blocked) |-> (status == cst_pkg::ST_OK && !wake_valid))
        else $error("blocked with bad status");
    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && wake_valid) |-> (status == cst_pkg::ST_OK && wake_pid != 16'd0))
        else $error("wake with bad status or dead pid");
    a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREAD) |-> (fill_reg != '0))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ rtl/core/cst_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire
